// ===== design/bff_pkg.sv =====
// ----------------------------------------------------------------------------
// bff_pkg
// Shared types and constants of the bitmap find-first-zero block.
// ----------------------------------------------------------------------------
package bff_pkg;

  // field widths
  localparam int IDX_W  = 10;
  localparam int CMD_W  = 2;

  // largest map that the 10-bit index can address
  localparam int MAX_BITS = 1 << IDX_W;

  // default map size
  localparam int BITS_DEF = 1024;

  // storage word of the flag memory
  localparam int WORD_W   = 64;
  localparam int WORD_LSB = $clog2(WORD_W);

  // command codes
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RMW  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIND = 4'b1000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // take the item and read its word
    logic update;   // modify word and summary bits
    logic scan;     // pick first non-full word and read it
    logic finish;   // load the result register
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new item
  } status_t;

endpackage

// ===== design/bff_if.sv =====
// ----------------------------------------------------------------------------
// bff_in_if / bff_out_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface bff_in_if import bff_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] bit_index;
  logic             write_value;

  modport source (output valid, output cmd, output bit_index, output write_value,
                  input ready);
  modport sink   (input valid, input cmd, input bit_index, input write_value,
                  output ready);
endinterface

interface bff_out_if import bff_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             bit_value;
  logic             index_valid;
  logic [IDX_W-1:0] first_zero_index;
  logic             zero_found;
  logic             all_clear;

  modport source (output valid, output bit_value, output index_valid,
                  output first_zero_index, output zero_found, output all_clear,
                  input ready);
  modport sink   (input valid, input bit_value, input index_valid,
                  input first_zero_index, input zero_found, input all_clear,
                  output ready);
endinterface

// ===== design/bff_ctrl.sv =====
// ----------------------------------------------------------------------------
// bff_ctrl
// Sequencer: accept, read-modify-write, word scan, bit search and result.
// ----------------------------------------------------------------------------
module bff_ctrl import bff_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t stat,
  output ctrl_t   ctrl
);

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_nxt    = S_RMW;
        end
      end
      S_RMW: begin
        ctrl.update = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
        state_nxt = S_FIND;
      end
      S_FIND: begin
        if (stat.out_free) begin
          ctrl.finish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/bff_dpath.sv =====
// ----------------------------------------------------------------------------
// bff_dpath
// Flag memory of 64-bit words with per-word valid, full and nonzero bits,
// first-zero search and the result register.
// ----------------------------------------------------------------------------
module bff_dpath import bff_pkg::*; #(
  parameter int BITS = BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_t            ctrl,
  output status_t          stat,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [IDX_W-1:0] in_bit_index,
  input  logic             in_write_value,
  bff_out_if.source        out_ch
);

  // only indices below MAX_BITS can ever be set
  localparam int EFF_BITS  = (BITS > MAX_BITS) ? MAX_BITS : BITS;
  localparam int NWORDS    = (EFF_BITS + WORD_W - 1) / WORD_W;
  localparam int WA        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CW        = WA + WORD_LSB + 1;
  localparam int EW        = $clog2(MAX_BITS) + 1;
  localparam logic TAIL_ZERO = (BITS > MAX_BITS);

  // flag memory and summary bits
  logic [WORD_W-1:0] mem [NWORDS];
  logic [NWORDS-1:0] wvalid_r, full_r, nz_r;

  // item registers
  logic [CMD_W-1:0]    cmd_r;
  logic [IDX_W-1:0]    idx_r;
  logic                val_r;
  logic                idx_ok_r;
  logic [WORD_W-1:0]   rd_word_r;
  logic                rd_wv_r;
  logic                bitv_r;
  logic [WA-1:0]       fw_r;
  logic                any_nf_r;
  logic                all_clear_r;

  // result register
  logic                out_valid_r;
  logic                out_bitv_r, out_ok_r, out_found_r, out_clear_r;
  logic [IDX_W-1:0]    out_first_r;

  // misc nets
  logic [WA-1:0]       in_wa, wa, fw_nxt, rd_addr;
  logic                any_nf_nxt;
  logic [WORD_LSB-1:0] bpos, zpos;
  logic [WORD_W-1:0]   cur_word, upd_word, find_word, find_ext, upd_exist, fw_exist;
  logic                do_write, bitv_nxt, idx_ok_in;

  // mask of bits of word w that lie below the map size
  function automatic logic [WORD_W-1:0] exist_mask(input logic [WA-1:0] w);
    logic [WORD_W-1:0] m;
    logic [CW-1:0]     pos;
    m = '0;
    for (int j = 0; j < WORD_W; j++) begin
      pos  = {1'b0, w, WORD_LSB'(j)};
      m[j] = (pos < CW'(EFF_BITS));
    end
    return m;
  endfunction

  assign in_wa     = in_bit_index[WORD_LSB +: WA];
  assign wa        = idx_r[WORD_LSB +: WA];
  assign bpos      = idx_r[WORD_LSB-1:0];
  assign idx_ok_in = ({1'b0, in_bit_index} < EW'(EFF_BITS));

  // read-modify-write of the addressed word
  assign cur_word  = rd_wv_r ? rd_word_r : '0;
  assign do_write  = (cmd_r == CMD_WRITE) && idx_ok_r;
  assign upd_exist = exist_mask(wa);
  always_comb begin
    upd_word = cur_word;
    if (do_write) begin
      upd_word[bpos] = val_r;
    end
  end
  assign bitv_nxt = (cmd_r == CMD_CLEAR) ? 1'b0 : (idx_ok_r & upd_word[bpos]);

  // lowest word that still has a zero
  always_comb begin
    fw_nxt     = '0;
    any_nf_nxt = 1'b0;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        fw_nxt     = WA'(i);
        any_nf_nxt = 1'b1;
      end
    end
  end

  // lowest zero bit of the selected word
  assign fw_exist  = exist_mask(fw_r);
  assign find_word = rd_wv_r ? rd_word_r : '0;
  assign find_ext  = find_word | ~fw_exist;
  always_comb begin
    zpos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (!find_ext[j]) begin
        zpos = WORD_LSB'(j);
      end
    end
  end

  // memory port: one write, one registered read
  assign rd_addr = ctrl.scan ? fw_nxt : in_wa;
  always_ff @(posedge clk) begin
    if (ctrl.update && do_write) begin
      mem[wa] <= upd_word;
    end
    if (ctrl.capture || ctrl.scan) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  // summary bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r <= '0;
      full_r   <= '0;
      nz_r     <= '0;
    end else if (ctrl.update) begin
      if (cmd_r == CMD_CLEAR) begin
        wvalid_r <= '0;
        full_r   <= '0;
        nz_r     <= '0;
      end else if (do_write) begin
        wvalid_r[wa] <= 1'b1;
        full_r[wa]   <= &(upd_word | ~upd_exist);
        nz_r[wa]     <= |upd_word;
      end
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r    <= in_cmd;
      idx_r    <= in_bit_index;
      val_r    <= in_write_value;
      idx_ok_r <= idx_ok_in;
      rd_wv_r  <= wvalid_r[in_wa];
    end
    if (ctrl.update) begin
      bitv_r <= bitv_nxt;
    end
    if (ctrl.scan) begin
      fw_r        <= fw_nxt;
      any_nf_r    <= any_nf_nxt;
      all_clear_r <= ~|nz_r;
      rd_wv_r     <= wvalid_r[fw_nxt];
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_bitv_r  <= bitv_r;
      out_ok_r    <= idx_ok_r;
      out_clear_r <= all_clear_r;
      out_found_r <= any_nf_r | TAIL_ZERO;
      out_first_r <= any_nf_r ? IDX_W'({fw_r, zpos}) : '0;
    end
  end

  assign stat.out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.bit_value        = out_bitv_r;
  assign out_ch.index_valid      = out_ok_r;
  assign out_ch.first_zero_index = out_first_r;
  assign out_ch.zero_found       = out_found_r;
  assign out_ch.all_clear        = out_clear_r;

endmodule

// ===== design/bitmap_find_first_zero_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_find_first_zero_core
// Bitmap of BITS flags with read, write and clear commands and a
// first-zero search after every command.
// ----------------------------------------------------------------------------
// usage:
//   in_ch  carries one command item: cmd (read, write, clear map),
//          bit_index and write_value; taken when valid and ready are high
//   out_ch carries one result item per command: addressed bit after the
//          command, index range flag, lowest zero index, zero found flag
//          and all-clear flag
//   sequence: an item passes the four sequencer steps in order, read of the
//          addressed word, its update, read of the first word that holds a
//          zero and result load; the next item is taken only after the load
//   flags live in 64-bit words with per-word valid, full and nonzero bits,
//          so reset and the clear command only reset the summary bits
//   reset: all flags read as zero, no result pending
//   stall: a result waits in the output register; the next item is still
//          taken and worked on, and its search holds until the register
//          frees up
// ----------------------------------------------------------------------------
module bitmap_find_first_zero_core import bff_pkg::*; #(
  parameter int BITS = BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bff_in_if.sink    in_ch,
  bff_out_if.source out_ch
);

  ctrl_t   ctrl;
  status_t stat;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  // sequencer
  bff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // memory, summary bits and search
  bff_dpath #(
    .BITS (BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .in_cmd         (in_ch.cmd),
    .in_bit_index   (in_ch.bit_index),
    .in_write_value (in_ch.write_value),
    .out_ch         (out_ch)
  );

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in work");

  // a new result only comes from the finish step
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(ctrl.finish))
    else $error("result valid without finish");

  // out-of-range index reads as zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.index_valid) |-> !out_ch.bit_value)
    else $error("out-of-range index returned a set bit");

  // a full map reports index zero
  a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.zero_found) |-> (out_ch.first_zero_index == '0))
    else $error("full map with nonzero first index");

  // an all-clear map always has a zero
  a_clear_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.all_clear) |-> (out_ch.zero_found &&
      out_ch.first_zero_index == '0))
    else $error("all-clear map without zero at index zero");

endmodule
